// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/wmd_pkg.sv
package wmd_pkg;

  // Window geometry
  localparam int WINDOW = 9;
  localparam int PATHS  = 4;
  localparam int KINDS  = 3;
  localparam int DIST_W = 24;
  localparam int PATH_W = 2;

  localparam int DEPTH  = PATHS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PCMP_W = PATH_W + 1;

  // Item kind codes
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Estimate lanes within a memory word
  localparam int K_IFFT  = 0;
  localparam int K_SLOPE = 1;
  localparam int K_RTT   = 2;

  typedef logic signed [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic  ok;
    dist_t value;
  } entry_t;

  typedef entry_t [KINDS-1:0] word_t;

  typedef struct packed {
    logic clr;
    logic ins;
  } sort_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MEDIAN
  } state_t;

  function automatic logic path_in_range(logic [PATH_W-1:0] p);
    return PCMP_W'(p) < PCMP_W'(PATHS);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(logic [PATH_W-1:0] p,
                                                logic [CNT_W-1:0] slot);
    return ADDR_W'(p) * ADDR_W'(WINDOW) + ADDR_W'(slot);
  endfunction

endpackage

// File: rtl/core/windowed_median_distance.sv
// Store item: accepted every cycle while no query runs; written to the ring memory
// at acceptance if its path is in range. Query item: ST_READ reads one ring entry per
// filled slot, then ST_DRAIN; ST_MEDIAN loads the result. Empty windows skip the reads.
// Queries are handled one at a time; the input stalls until the result register frees.
// Reset: ring reads as zero/valid, write slot and fill count zero, no result pending.
module windowed_median_distance (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [wmd_pkg::PATH_W-1:0]    path,
  input  logic signed [23:0]            ifft_dist,
  input  logic                          ifft_ok,
  input  logic signed [23:0]            slope_dist,
  input  logic                          slope_ok,
  input  logic signed [23:0]            rtt_dist,
  input  logic                          rtt_ok,
  input  logic                          report_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [23:0]            ifft_median,
  output logic                          ifft_present,
  output logic signed [23:0]            slope_median,
  output logic                          slope_present,
  output logic signed [23:0]            rtt_median,
  output logic                          rtt_present
);
  import wmd_pkg::*;

  state_t             state;
  state_t             state_next;
  logic               accept;
  logic               store_go;
  logic               query_go;
  logic               rd_en;
  logic               out_load;
  logic               rd_vld;
  logic [ADDR_W-1:0]  base;
  logic [CNT_W-1:0]   rd_idx;
  logic [SLOT_W-1:0]  write_slot;
  logic [CNT_W-1:0]   fill_count;
  word_t              wdata;
  word_t              rdata;
  sort_ctrl_t         sctrl [KINDS];
  dist_t              med [KINDS];
  logic [KINDS-1:0]   pres;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign store_go = accept && (kind == KIND_STORE);
  assign query_go = accept && (kind == KIND_QUERY);

  // Store word
  always_comb begin
    wdata[K_IFFT]  = '{ok: ifft_ok,  value: ifft_dist};
    wdata[K_SLOPE] = '{ok: slope_ok, value: slope_dist};
    wdata[K_RTT]   = '{ok: rtt_ok,   value: rtt_dist};
  end

  wmd_ring_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (store_go && path_in_range(path)),
    .waddr (addr_of(path, CNT_W'(write_slot))),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (base + ADDR_W'(rd_idx)),
    .rdata (rdata)
  );

  // Ring position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (store_go && report_end) begin
      write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);
      if (fill_count != CNT_W'(WINDOW)) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  // Query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (query_go) begin
          state_next = (path_in_range(path) && fill_count != '0) ? ST_READ : ST_MEDIAN;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (rd_idx + CNT_W'(1) == fill_count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MEDIAN;
      end
      ST_MEDIAN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Read address walk
  always_ff @(posedge clk) begin
    if (query_go) begin
      base   <= addr_of(path, '0);
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // One sorter per estimate kind
  for (genvar k = 0; k < KINDS; k++) begin : g_sort
    always_comb begin
      sctrl[k].clr = query_go;
      sctrl[k].ins = rd_vld && rdata[k].ok;
    end

    wmd_median_sort u_sort (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (sctrl[k]),
      .din     (rdata[k].value),
      .median  (med[k]),
      .present (pres[k])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ifft_median   <= med[K_IFFT];
      ifft_present  <= pres[K_IFFT];
      slope_median  <= med[K_SLOPE];
      slope_present <= pres[K_SLOPE];
      rtt_median    <= med[K_RTT];
      rtt_present   <= pres[K_RTT];
    end
  end

endmodule

// File: rtl/core/wmd_ring_mem.sv
module wmd_ring_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [wmd_pkg::ADDR_W-1:0]  waddr,
  input  wmd_pkg::word_t              wdata,
  input  logic                        re,
  input  logic [wmd_pkg::ADDR_W-1:0]  raddr,
  output wmd_pkg::word_t              rdata
);
  import wmd_pkg::*;

  word_t             mem [DEPTH];
  logic [DEPTH-1:0]  written;
  word_t             rd_word;
  logic              rd_hit;
  word_t             reset_word;

  // Entries never written read back as zero, flagged valid
  always_comb begin
    for (int k = 0; k < KINDS; k++) begin
      reset_word[k].ok    = 1'b1;
      reset_word[k].value = '0;
    end
  end

  // Per-entry written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_word <= mem[raddr];
      rd_hit  <= written[raddr];
    end
  end

  assign rdata = rd_hit ? rd_word : reset_word;

endmodule

// File: rtl/core/wmd_median_sort.sv
module wmd_median_sort (
  input  logic                 clk,
  input  logic                 rst,
  input  wmd_pkg::sort_ctrl_t  ctrl,
  input  wmd_pkg::dist_t       din,
  output wmd_pkg::dist_t       median,
  output logic                 present
);
  import wmd_pkg::*;

  dist_t              vals [WINDOW];
  dist_t              vals_next [WINDOW];
  logic [CNT_W-1:0]   n;
  logic [WINDOW-1:0]  keep;
  logic [CNT_W-1:0]   lo_idx;
  logic [CNT_W-1:0]   hi_idx;
  logic signed [DIST_W:0] pair_sum;

  // Sorted list: entries at or below the new value stay, the rest shift up
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      keep[i] = (CNT_W'(i) < n) && (vals[i] <= din);
    end
    for (int i = 0; i < WINDOW; i++) begin
      if (keep[i]) begin
        vals_next[i] = vals[i];
      end else if (i == 0) begin
        vals_next[i] = din;
      end else if (keep[(i > 0) ? i - 1 : 0]) begin
        vals_next[i] = din;
      end else begin
        vals_next[i] = vals[(i > 0) ? i - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      n <= '0;
    end else if (ctrl.ins) begin
      n <= n + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      vals <= vals_next;
    end
  end

  // Middle pair; for an odd count both pick the same entry
  assign lo_idx   = (n - CNT_W'(1)) >> 1;
  assign hi_idx   = n >> 1;
  assign pair_sum = {vals[lo_idx[SLOT_W-1:0]][DIST_W-1], vals[lo_idx[SLOT_W-1:0]]}
                  + {vals[hi_idx[SLOT_W-1:0]][DIST_W-1], vals[hi_idx[SLOT_W-1:0]]};

  assign present = (n != '0);
  assign median  = present ? dist_t'(pair_sum[DIST_W:1]) : '0;

endmodule

// File: rtl/core/wmd_checker.sv
`include "assert_macros.svh"

module wmd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [23:0]          ifft_median,
  input logic                        ifft_present,
  input logic signed [23:0]          slope_median,
  input logic                        slope_present,
  input logic signed [23:0]          rtt_median,
  input logic                        rtt_present
);
  import wmd_pkg::*;

  logic [KINDS*DIST_W-1:0] meds;
  logic                    absent_zero;

  assign meds        = {ifft_median, slope_median, rtt_median};
  assign absent_zero = (ifft_present || ifft_median == 0)
                    && (slope_present || slope_median == 0)
                    && (rtt_present || rtt_median == 0);

  // A stalled result holds
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(meds))

  // An absent kind reports a zero median
  `ASSERT_IMP(a_absent_zero, clk, rst, out_valid, absent_zero)

  // A query holds off the input while it runs
  `ASSERT_NXT(a_query_busy, clk, rst, in_valid && in_ready && kind == KIND_QUERY, !in_ready)

  // Reset empties the result register
  `ASSERT_NXT_ALL(a_reset_empty, clk, rst, !out_valid)

endmodule

bind windowed_median_distance wmd_checker u_wmd_checker (.*);

// File: tb/tb_windowed_median_distance.sv
module tb_windowed_median_distance;
  import wmd_pkg::*;

  localparam dist_t DIST_MAX = dist_t'(8388607);
  localparam dist_t DIST_MIN = dist_t'(-8388608);
  localparam int SETTLE_CYCLES = 2 * WINDOW + 8;

  // one input item, lanes indexed by K_IFFT / K_SLOPE / K_RTT
  typedef struct packed {
    logic                  kind;
    logic [PATH_W-1:0]     path;
    dist_t [KINDS-1:0]     est;
    logic [KINDS-1:0]      ok;
    logic                  report_end;
  } item_t;

  // one query result
  typedef struct packed {
    dist_t [KINDS-1:0] med;
    logic [KINDS-1:0]  present;
  } medians_t;

  // Scoreboard: shadow copy of the ring store, predicted medians in order
  class median_scoreboard;
    entry_t      ring [KINDS][PATHS][WINDOW];
    int unsigned slot;
    int unsigned filled;
    medians_t    expected_q[$];
    int          mismatches;
    int          checked;
    int          stores;
    int          queries;

    function new();
      for (int k = 0; k < KINDS; k++) begin
        for (int p = 0; p < PATHS; p++) begin
          for (int s = 0; s < WINDOW; s++) begin
            ring[k][p][s].ok = 1'b1;
            ring[k][p][s].value = '0;
          end
        end
      end
      slot = 0;
      filled = 0;
      mismatches = 0;
      checked = 0;
      stores = 0;
      queries = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endfunction

    // median of the valid, counted entries of one path and lane
    function void lane_median(int k, int p, output dist_t med, output logic present);
      dist_t                  vals [WINDOW];
      int                     n;
      int                     j;
      logic signed [DIST_W:0] sum;
      n = 0;
      for (int s = 0; s < filled; s++) begin
        if (ring[k][p][s].ok) begin
          j = n;
          while (j > 0 && vals[j-1] > ring[k][p][s].value) begin
            vals[j] = vals[j-1];
            j--;
          end
          vals[j] = ring[k][p][s].value;
          n++;
        end
      end
      if (n == 0) begin
        med = '0;
        present = 1'b0;
      end else if (n % 2 == 1) begin
        med = vals[n/2];
        present = 1'b1;
      end else begin
        // floor of the mean of the two middle values
        sum = (DIST_W+1)'(vals[n/2]) + (DIST_W+1)'(vals[n/2-1]);
        med = dist_t'(sum >>> 1);
        present = 1'b1;
      end
    endfunction

    function void note_item(item_t it);
      medians_t exp_res;
      if (it.kind == KIND_STORE) begin
        stores++;
        if (int'(it.path) < PATHS) begin
          for (int k = 0; k < KINDS; k++) begin
            ring[k][it.path][slot].value = it.est[k];
            ring[k][it.path][slot].ok = it.ok[k];
          end
        end
        if (it.report_end) begin
          slot = (slot + 1) % WINDOW;
          if (filled < WINDOW) begin
            filled++;
          end
        end
      end else begin
        queries++;
        exp_res = '0;
        if (int'(it.path) < PATHS) begin
          for (int k = 0; k < KINDS; k++) begin
            lane_median(k, it.path, exp_res.med[k], exp_res.present[k]);
          end
        end
        expected_q.push_back(exp_res);
      end
    endfunction

    function void check_result(medians_t got);
      medians_t exp_res;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with no query outstanding (ifft %0d/%0b)",
                       got.med[K_IFFT], got.present[K_IFFT]));
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      for (int k = 0; k < KINDS; k++) begin
        if (got.med[k] !== exp_res.med[k] || got.present[k] !== exp_res.present[k]) begin
          flag($sformatf("result %0d lane %0d: expected median %0d present %0b, got %0d %0b",
                         checked, k, exp_res.med[k], exp_res.present[k],
                         got.med[k], got.present[k]));
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_STORE;
  logic [PATH_W-1:0] path = '0;
  logic signed [23:0] ifft_dist = '0;
  logic              ifft_ok = 1'b0;
  logic signed [23:0] slope_dist = '0;
  logic              slope_ok = 1'b0;
  logic signed [23:0] rtt_dist = '0;
  logic              rtt_ok = 1'b0;
  logic              report_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [23:0] ifft_median;
  logic              ifft_present;
  logic signed [23:0] slope_median;
  logic              slope_present;
  logic signed [23:0] rtt_median;
  logic              rtt_present;

  median_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;
  int items_sent = 0;

  windowed_median_distance DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .path(path),
    .ifft_dist(ifft_dist), .ifft_ok(ifft_ok),
    .slope_dist(slope_dist), .slope_ok(slope_ok),
    .rtt_dist(rtt_dist), .rtt_ok(rtt_ok),
    .report_end(report_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .ifft_median(ifft_median), .ifft_present(ifft_present),
    .slope_median(slope_median), .slope_present(slope_present),
    .rtt_median(rtt_median), .rtt_present(rtt_present)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result side: check on handshake, then pick next ready
  always @(posedge clk) begin
    medians_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.med[K_IFFT] = ifft_median;
        got.med[K_SLOPE] = slope_median;
        got.med[K_RTT] = rtt_median;
        got.present[K_IFFT] = ifft_present;
        got.present[K_SLOPE] = slope_present;
        got.present[K_RTT] = rtt_present;
        sb.check_result(got);
      end
      out_ready <= (hold_cnt == 0) && (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  function automatic dist_t rand_dist();
    case ($urandom_range(9))
      0: return DIST_MIN;
      1: return DIST_MAX;
      2: return '0;
      3: return dist_t'(-1);
      4, 5, 6: return dist_t'(int'($urandom_range(40)) - 20);
      default: return dist_t'($urandom());
    endcase
  endfunction

  function automatic item_t make_store(logic [PATH_W-1:0] p, logic re, int ok_pct);
    item_t it;
    it.kind = KIND_STORE;
    it.path = p;
    for (int k = 0; k < KINDS; k++) begin
      it.est[k] = rand_dist();
      it.ok[k] = int'($urandom_range(99)) < ok_pct;
    end
    it.report_end = re;
    return it;
  endfunction

  // query; the unused fields carry random bits
  function automatic item_t make_query(logic [PATH_W-1:0] p);
    item_t it;
    it.kind = KIND_QUERY;
    it.path = p;
    for (int k = 0; k < KINDS; k++) begin
      it.est[k] = dist_t'($urandom());
    end
    it.ok = KINDS'($urandom());
    it.report_end = 1'($urandom());
    return it;
  endfunction

  function automatic item_t make_fixed(logic [PATH_W-1:0] p, dist_t a, dist_t b, dist_t c,
                                       logic [KINDS-1:0] ok, logic re);
    item_t it;
    it.kind = KIND_STORE;
    it.path = p;
    it.est[K_IFFT] = a;
    it.est[K_SLOPE] = b;
    it.est[K_RTT] = c;
    it.ok = ok;
    it.report_end = re;
    return it;
  endfunction

  // offer one item, hold it until accepted
  task automatic send_item(input item_t it);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    path <= it.path;
    ifft_dist <= it.est[K_IFFT];
    ifft_ok <= it.ok[K_IFFT];
    slope_dist <= it.est[K_SLOPE];
    slope_ok <= it.ok[K_SLOPE];
    rtt_dist <= it.est[K_RTT];
    rtt_ok <= it.ok[K_RTT];
    report_end <= it.report_end;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_item(it);
    items_sent++;
  endtask

  // sender pauses until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_directed();
    // empty window
    send_item(make_query(2'd0));
    // path 2 all invalid, path 0 max, path 1 min, then advance
    send_item(make_fixed(2'd2, DIST_MAX, DIST_MIN, dist_t'(5), 3'b000, 1'b0));
    send_item(make_fixed(2'd0, DIST_MAX, DIST_MAX, DIST_MAX, 3'b111, 1'b0));
    send_item(make_fixed(2'd1, DIST_MIN, DIST_MIN, DIST_MIN, 3'b111, 1'b1));
    send_item(make_query(2'd2));
    send_item(make_query(2'd0));
    send_item(make_query(2'd1));
    // path 3 never written: reset zeros count as valid
    send_item(make_query(2'd3));
    // two-entry window: mean of max and min floors to -1; ifft flag cleared
    send_item(make_fixed(2'd0, DIST_MIN, DIST_MIN, DIST_MIN, 3'b110, 1'b1));
    send_item(make_query(2'd0));
    // overwrite the same slot before advancing
    send_item(make_fixed(2'd0, dist_t'(-1), dist_t'(0), dist_t'(1), 3'b111, 1'b0));
    send_item(make_fixed(2'd0, dist_t'(7), dist_t'(-3), dist_t'(4), 3'b101, 1'b1));
    send_item(make_query(2'd0));
    // push past the window size so the fill count saturates and the slot wraps
    for (int i = 0; i < 8; i++) begin
      send_item(make_store(2'(i), 1'b1, 80));
    end
    send_item(make_query(2'd1));
    send_item(make_query(2'd0));
    send_item(make_query(2'd3));
  endtask

  // mostly complete reports followed by queries, plus broken reports and noise
  task automatic run_random(int target);
    int          done;
    int          npaths;
    int          start;
    int          ok_pct;
    int          nq;
    item_t       it;
    done = 0;
    while (done < target) begin
      case ($urandom_range(9))
        0: begin
          it = make_store(2'($urandom()), 1'($urandom()), 50);
          if ($urandom_range(1) == 1) begin
            it = make_query(2'($urandom()));
          end
          send_item(it);
          done++;
        end
        1: begin
          // report cut short: no slot advance
          npaths = $urandom_range(1, 3);
          for (int i = 0; i < npaths; i++) begin
            send_item(make_store(2'($urandom()), 1'b0, 70));
          end
          done += npaths;
        end
        default: begin
          npaths = ($urandom_range(3) == 0) ? $urandom_range(1, PATHS) : PATHS;
          start = $urandom_range(PATHS - 1);
          ok_pct = ($urandom_range(4) == 0) ? 15 : 85;
          for (int i = 0; i < npaths; i++) begin
            send_item(make_store(2'((start + i) % PATHS), 1'(i == npaths - 1), ok_pct));
          end
          nq = $urandom_range(0, 3);
          for (int i = 0; i < nq; i++) begin
            send_item(make_query(2'($urandom())));
          end
          done += npaths + nq;
        end
      endcase
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic backpressure_burst();
    while (hold_cnt != 0) begin
      @(posedge clk);
    end
    hold_cnt <= 400;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) begin
        send_item(make_query(2'($urandom())));
      end else begin
        send_item(make_store(2'($urandom()), 1'($urandom()), 85));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain();

    // pacing phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 72; end
        default: begin send_idle_pct = 35; recv_stall_pct <= 35; end
      endcase
      run_random(100);
      if (ph == 0 || ph == 2) begin
        backpressure_burst();
      end
      drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d stores, %0d queries); checked %0d median results",
             items_sent, sb.stores, sb.queries, sb.checked);
    $display("Pacing covered free flow, sender gaps, receiver stalls, both, and long hold-offs");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/wmd_pkg.sv
rtl/core/wmd_ring_mem.sv
rtl/core/wmd_median_sort.sv
rtl/core/windowed_median_distance.sv
rtl/core/wmd_checker.sv
tb/tb_windowed_median_distance.sv
